>>> design/sacs_pkg.sv
// ----------------------------------------------------------------------------
// sacs_pkg
// Shared types and constants for the suffix automaton common substring block.
// ----------------------------------------------------------------------------
`default_nettype none

package sacs_pkg;

    localparam int MAX_REF_LEN = 256;
    localparam int ALPHABET    = 256;
    localparam int NODE_CAP    = 2 * MAX_REF_LEN;
    localparam int SYM_W       = $clog2(ALPHABET);
    localparam int NODE_W      = $clog2(NODE_CAP);
    localparam int CNT_W       = NODE_W + 1;
    localparam int LEN_W       = $clog2(MAX_REF_LEN + 1);
    localparam int LINK_W      = NODE_W + 1;
    localparam int EDGE_AW     = NODE_W + SYM_W;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_MATCH   = 2'd3
    } t_mode;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_RESTART, ST_A0, ST_A1, ST_LRD, ST_LCHK,
        ST_QGOT, ST_QCMP, ST_CBMP, ST_CRD, ST_CWR, ST_RRD, ST_RCHK,
        ST_REND1, ST_REND2, ST_AFIN, ST_MRD, ST_MCHK, ST_MLEN, ST_MBEST,
        ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        CMD_NOP, CMD_INIT, CMD_ACCEPT, CMD_RESTART, CMD_A0, CMD_A1, CMD_LRD,
        CMD_LCHK, CMD_QGOT, CMD_QCMP, CMD_CBMP, CMD_CRD, CMD_CWR, CMD_RRD,
        CMD_RCHK, CMD_REND1, CMD_REND2, CMD_AFIN, CMD_MRD, CMD_MCHK,
        CMD_MLEN, CMD_MBEST, CMD_DONE
    } t_cmd;

    typedef struct packed {
        logic full;
        logic edge_hit;
        logic link_none;
        logic len_solid;
        logic redirect_hit;
        logic copy_last;
        logic qnode_root;
    } t_status;

endpackage

`default_nettype wire

>>> design/sacs_ctrl.sv
// ----------------------------------------------------------------------------
// sacs_ctrl
// Sequencer: walks the build, clone and match steps and issues one command
// to the datapath per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sacs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       i_mode,
    input  sacs_pkg::t_status     i_status,
    output sacs_pkg::t_cmd        o_cmd,
    output logic                  busy
);

    sacs_pkg::t_state r_state, n_state;
    logic r_from_clear, n_from_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sacs_pkg::ST_INIT;
            r_from_clear <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_from_clear <= n_from_clear;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_from_clear = r_from_clear;
        o_cmd        = sacs_pkg::CMD_NOP;
        case (r_state)
            sacs_pkg::ST_INIT: begin
                o_cmd        = sacs_pkg::CMD_INIT;
                n_state      = r_from_clear ? sacs_pkg::ST_DONE : sacs_pkg::ST_IDLE;
                n_from_clear = 1'b0;
            end
            sacs_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd = sacs_pkg::CMD_ACCEPT;
                    case (sacs_pkg::t_mode'(i_mode))
                        sacs_pkg::MODE_CLEAR: begin
                            n_state      = sacs_pkg::ST_INIT;
                            n_from_clear = 1'b1;
                        end
                        sacs_pkg::MODE_APPEND:
                            n_state = i_status.full ? sacs_pkg::ST_DONE : sacs_pkg::ST_A0;
                        sacs_pkg::MODE_RESTART: n_state = sacs_pkg::ST_RESTART;
                        default: n_state = sacs_pkg::ST_MRD;
                    endcase
                end
            end
            sacs_pkg::ST_RESTART: begin
                o_cmd   = sacs_pkg::CMD_RESTART;
                n_state = sacs_pkg::ST_DONE;
            end
            sacs_pkg::ST_A0: begin
                o_cmd   = sacs_pkg::CMD_A0;
                n_state = sacs_pkg::ST_A1;
            end
            sacs_pkg::ST_A1: begin
                o_cmd   = sacs_pkg::CMD_A1;
                n_state = sacs_pkg::ST_LRD;
            end
            sacs_pkg::ST_LRD: begin
                o_cmd   = sacs_pkg::CMD_LRD;
                n_state = sacs_pkg::ST_LCHK;
            end
            sacs_pkg::ST_LCHK: begin
                o_cmd = sacs_pkg::CMD_LCHK;
                if (i_status.edge_hit)
                    n_state = sacs_pkg::ST_QGOT;
                else if (i_status.link_none)
                    n_state = sacs_pkg::ST_AFIN;
                else
                    n_state = sacs_pkg::ST_LRD;
            end
            sacs_pkg::ST_QGOT: begin
                o_cmd   = sacs_pkg::CMD_QGOT;
                n_state = sacs_pkg::ST_QCMP;
            end
            sacs_pkg::ST_QCMP: begin
                o_cmd   = sacs_pkg::CMD_QCMP;
                n_state = i_status.len_solid ? sacs_pkg::ST_AFIN : sacs_pkg::ST_CBMP;
            end
            sacs_pkg::ST_CBMP: begin
                o_cmd   = sacs_pkg::CMD_CBMP;
                n_state = sacs_pkg::ST_CRD;
            end
            sacs_pkg::ST_CRD: begin
                o_cmd   = sacs_pkg::CMD_CRD;
                n_state = sacs_pkg::ST_CWR;
            end
            sacs_pkg::ST_CWR: begin
                o_cmd   = sacs_pkg::CMD_CWR;
                n_state = i_status.copy_last ? sacs_pkg::ST_RRD : sacs_pkg::ST_CRD;
            end
            sacs_pkg::ST_RRD: begin
                o_cmd   = sacs_pkg::CMD_RRD;
                n_state = sacs_pkg::ST_RCHK;
            end
            sacs_pkg::ST_RCHK: begin
                o_cmd = sacs_pkg::CMD_RCHK;
                if (i_status.redirect_hit && !i_status.link_none)
                    n_state = sacs_pkg::ST_RRD;
                else
                    n_state = sacs_pkg::ST_REND1;
            end
            sacs_pkg::ST_REND1: begin
                o_cmd   = sacs_pkg::CMD_REND1;
                n_state = sacs_pkg::ST_REND2;
            end
            sacs_pkg::ST_REND2: begin
                o_cmd   = sacs_pkg::CMD_REND2;
                n_state = sacs_pkg::ST_AFIN;
            end
            sacs_pkg::ST_AFIN: begin
                o_cmd   = sacs_pkg::CMD_AFIN;
                n_state = sacs_pkg::ST_DONE;
            end
            sacs_pkg::ST_MRD: begin
                o_cmd   = sacs_pkg::CMD_MRD;
                n_state = sacs_pkg::ST_MCHK;
            end
            sacs_pkg::ST_MCHK: begin
                o_cmd = sacs_pkg::CMD_MCHK;
                if (i_status.edge_hit || i_status.qnode_root)
                    n_state = sacs_pkg::ST_MBEST;
                else
                    n_state = sacs_pkg::ST_MLEN;
            end
            sacs_pkg::ST_MLEN: begin
                o_cmd   = sacs_pkg::CMD_MLEN;
                n_state = sacs_pkg::ST_MRD;
            end
            sacs_pkg::ST_MBEST: begin
                o_cmd   = sacs_pkg::CMD_MBEST;
                n_state = sacs_pkg::ST_DONE;
            end
            sacs_pkg::ST_DONE: begin
                o_cmd   = sacs_pkg::CMD_DONE;
                n_state = sacs_pkg::ST_IDLE;
            end
            default: n_state = sacs_pkg::ST_INIT;
        endcase
    end

    assign busy = (r_state != sacs_pkg::ST_IDLE);

endmodule

`default_nettype wire

>>> design/sacs_dp.sv
// ----------------------------------------------------------------------------
// sacs_dp
// Datapath: node tables, transition bitmaps and targets, build and match
// registers, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sacs_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  sacs_pkg::t_cmd                   i_cmd,
    input  wire logic [1:0]                  i_mode,
    input  wire logic [sacs_pkg::SYM_W-1:0]  i_symbol,
    output sacs_pkg::t_status                o_status,
    output logic                             o_valid,
    output logic [sacs_pkg::LEN_W-1:0]       o_longest_match,
    output logic [sacs_pkg::LEN_W-1:0]       o_current_match,
    output logic                             o_reference_full
);

    localparam int ROW_W = sacs_pkg::ALPHABET;

    // memories
    logic [sacs_pkg::LEN_W-1:0]  len_mem  [sacs_pkg::NODE_CAP];
    logic [sacs_pkg::LINK_W-1:0] link_mem [sacs_pkg::NODE_CAP];
    logic [ROW_W-1:0]            bmp_mem  [sacs_pkg::NODE_CAP];
    logic [sacs_pkg::NODE_W-1:0] tgt_mem  [sacs_pkg::NODE_CAP * sacs_pkg::ALPHABET];

    logic [sacs_pkg::LEN_W-1:0]   r_len_rd;
    logic [sacs_pkg::LINK_W-1:0]  r_link_rd;
    logic [ROW_W-1:0]             r_bmp_rd;
    logic [sacs_pkg::NODE_W-1:0]  r_tgt_rd;

    logic                         len_we, link_we, bmp_we, tgt_we;
    logic [sacs_pkg::NODE_W-1:0]  len_ra, len_wa, link_ra, link_wa, bmp_ra, bmp_wa;
    logic [sacs_pkg::EDGE_AW-1:0] tgt_ra, tgt_wa;
    logic [sacs_pkg::LEN_W-1:0]   len_wd;
    logic [sacs_pkg::LINK_W-1:0]  link_wd;
    logic [ROW_W-1:0]             bmp_wd;
    logic [sacs_pkg::NODE_W-1:0]  tgt_wd;

    // control registers
    logic [sacs_pkg::CNT_W-1:0]  r_nodes_used;
    logic [sacs_pkg::NODE_W-1:0] r_tail, r_qnode;
    logic [sacs_pkg::LEN_W-1:0]  r_ref_len, r_qlen, r_best;
    logic                        r_full, r_valid;
    // work registers
    logic [sacs_pkg::SYM_W-1:0]  r_sym, r_cnt;
    logic [sacs_pkg::NODE_W-1:0] r_cur, r_p, r_q, r_r;
    logic [sacs_pkg::LEN_W-1:0]  r_lenp;
    logic [sacs_pkg::LEN_W-1:0]  r_out_best, r_out_cur;
    logic                        r_out_full;

    logic [sacs_pkg::LINK_W-1:0] link_none;
    logic [sacs_pkg::NODE_W-1:0] r_link_node;

    assign link_none   = {1'b1, {sacs_pkg::NODE_W{1'b0}}};
    assign r_link_node = r_link_rd[sacs_pkg::NODE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (len_we) len_mem[len_wa] <= len_wd;
        r_len_rd <= len_mem[len_ra];
    end

    always_ff @(posedge i_clk) begin
        if (link_we) link_mem[link_wa] <= link_wd;
        r_link_rd <= link_mem[link_ra];
    end

    always_ff @(posedge i_clk) begin
        if (bmp_we) bmp_mem[bmp_wa] <= bmp_wd;
        r_bmp_rd <= bmp_mem[bmp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
        r_tgt_rd <= tgt_mem[tgt_ra];
    end

    // status
    always_comb begin
        o_status.full = (r_ref_len >= sacs_pkg::LEN_W'(sacs_pkg::MAX_REF_LEN)) ||
            ((r_nodes_used + sacs_pkg::CNT_W'(2)) >
             sacs_pkg::CNT_W'(sacs_pkg::NODE_CAP));
        o_status.edge_hit     = r_bmp_rd[r_sym];
        o_status.link_none    = r_link_rd[sacs_pkg::LINK_W-1];
        o_status.len_solid    = ((r_lenp + sacs_pkg::LEN_W'(1)) == r_len_rd);
        o_status.redirect_hit = r_bmp_rd[r_sym] && (r_tgt_rd == r_q);
        o_status.copy_last    = (r_cnt == sacs_pkg::SYM_W'(sacs_pkg::ALPHABET - 1));
        o_status.qnode_root   = (r_qnode == '0);
    end

    // memory port steering
    always_comb begin
        len_we  = 1'b0;  len_wa  = r_cur;  len_wd  = r_len_rd + sacs_pkg::LEN_W'(1);
        link_we = 1'b0;  link_wa = r_cur;  link_wd = '0;
        bmp_we  = 1'b0;  bmp_wa  = r_p;    bmp_wd  = r_bmp_rd | (ROW_W'(1) << r_sym);
        tgt_we  = 1'b0;  tgt_wa  = {r_p, r_sym};  tgt_wd = r_cur;
        len_ra  = r_p;
        link_ra = r_p;
        bmp_ra  = r_p;
        tgt_ra  = {r_p, r_sym};
        case (i_cmd)
            sacs_pkg::CMD_INIT: begin
                len_we  = 1'b1;  len_wa  = '0;  len_wd  = '0;
                link_we = 1'b1;  link_wa = '0;  link_wd = link_none;
                bmp_we  = 1'b1;  bmp_wa  = '0;  bmp_wd  = '0;
            end
            sacs_pkg::CMD_A0: begin
                len_ra = r_tail;
                bmp_we = 1'b1;
                bmp_wa = r_nodes_used[sacs_pkg::NODE_W-1:0];
                bmp_wd = '0;
            end
            sacs_pkg::CMD_A1: len_we = 1'b1;
            sacs_pkg::CMD_LCHK: begin
                if (!o_status.edge_hit) begin
                    bmp_we = 1'b1;
                    tgt_we = 1'b1;
                    link_we = o_status.link_none;
                end
            end
            sacs_pkg::CMD_QGOT: len_ra = r_tgt_rd;
            sacs_pkg::CMD_QCMP: begin
                link_ra = r_q;
                bmp_ra  = r_q;
                if (o_status.len_solid) begin
                    link_we = 1'b1;
                    link_wd = {1'b0, r_q};
                end else begin
                    len_we = 1'b1;
                    len_wa = r_nodes_used[sacs_pkg::NODE_W-1:0];
                    len_wd = r_lenp + sacs_pkg::LEN_W'(1);
                end
            end
            sacs_pkg::CMD_CBMP: begin
                bmp_we  = 1'b1;  bmp_wa  = r_r;  bmp_wd  = r_bmp_rd;
                link_we = 1'b1;  link_wa = r_r;  link_wd = r_link_rd;
            end
            sacs_pkg::CMD_CRD: tgt_ra = {r_q, r_cnt};
            sacs_pkg::CMD_CWR: begin
                tgt_we = 1'b1;
                tgt_wa = {r_r, r_cnt};
                tgt_wd = r_tgt_rd;
            end
            sacs_pkg::CMD_RCHK: begin
                tgt_we = o_status.redirect_hit;
                tgt_wd = r_r;
            end
            sacs_pkg::CMD_REND1: begin
                link_we = 1'b1;  link_wa = r_q;  link_wd = {1'b0, r_r};
            end
            sacs_pkg::CMD_REND2: begin
                link_we = 1'b1;  link_wd = {1'b0, r_r};
            end
            sacs_pkg::CMD_MRD: begin
                link_ra = r_qnode;
                bmp_ra  = r_qnode;
                tgt_ra  = {r_qnode, r_sym};
            end
            sacs_pkg::CMD_MCHK: len_ra = r_link_node;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes_used <= sacs_pkg::CNT_W'(1);
            r_tail       <= '0;
            r_ref_len    <= '0;
            r_qnode      <= '0;
            r_qlen       <= '0;
            r_best       <= '0;
            r_full       <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= (i_cmd == sacs_pkg::CMD_DONE);
            case (i_cmd)
                sacs_pkg::CMD_INIT: begin
                    r_nodes_used <= sacs_pkg::CNT_W'(1);
                    r_tail       <= '0;
                    r_ref_len    <= '0;
                    r_qnode      <= '0;
                    r_qlen       <= '0;
                    r_best       <= '0;
                end
                sacs_pkg::CMD_ACCEPT:
                    r_full <= (sacs_pkg::t_mode'(i_mode) == sacs_pkg::MODE_APPEND) &&
                              o_status.full;
                sacs_pkg::CMD_RESTART: begin
                    r_qnode <= '0;
                    r_qlen  <= '0;
                    r_best  <= '0;
                end
                sacs_pkg::CMD_A0: r_nodes_used <= r_nodes_used + sacs_pkg::CNT_W'(1);
                sacs_pkg::CMD_QCMP:
                    if (!o_status.len_solid)
                        r_nodes_used <= r_nodes_used + sacs_pkg::CNT_W'(1);
                sacs_pkg::CMD_AFIN: begin
                    r_tail    <= r_cur;
                    r_ref_len <= r_ref_len + sacs_pkg::LEN_W'(1);
                end
                sacs_pkg::CMD_MCHK: begin
                    if (o_status.edge_hit) begin
                        r_qnode <= r_tgt_rd;
                        r_qlen  <= r_qlen + sacs_pkg::LEN_W'(1);
                    end else if (!o_status.qnode_root) begin
                        r_qnode <= r_link_node;
                    end
                end
                sacs_pkg::CMD_MLEN: r_qlen <= r_len_rd;
                sacs_pkg::CMD_MBEST: if (r_qlen > r_best) r_best <= r_qlen;
                default: ;
            endcase
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            sacs_pkg::CMD_ACCEPT: r_sym <= i_symbol;
            sacs_pkg::CMD_A0: begin
                r_cur <= r_nodes_used[sacs_pkg::NODE_W-1:0];
                r_p   <= r_tail;
            end
            sacs_pkg::CMD_LCHK: begin
                r_lenp <= r_len_rd;
                // hold p on a hit: the redirection starts there
                if (!o_status.edge_hit) r_p <= r_link_node;
            end
            sacs_pkg::CMD_QGOT: r_q <= r_tgt_rd;
            sacs_pkg::CMD_QCMP: r_r <= r_nodes_used[sacs_pkg::NODE_W-1:0];
            sacs_pkg::CMD_CBMP: r_cnt <= '0;
            sacs_pkg::CMD_CWR: r_cnt <= r_cnt + sacs_pkg::SYM_W'(1);
            sacs_pkg::CMD_RCHK: r_p <= r_link_node;
            sacs_pkg::CMD_DONE: begin
                r_out_best <= r_best;
                r_out_cur  <= r_qlen;
                r_out_full <= r_full;
            end
            default: ;
        endcase
    end

    assign o_valid          = r_valid;
    assign o_longest_match  = r_out_best;
    assign o_current_match  = r_out_cur;
    assign o_reference_full = r_out_full;

`ifndef SYNTH
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid) else $error("result strobe longer than one cycle");
    a_node_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nodes_used <= sacs_pkg::CNT_W'(sacs_pkg::NODE_CAP))
        else $error("node count beyond capacity");
    a_best_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_out_best >= r_out_cur))
        else $error("current match longer than best match");
`endif

endmodule

`default_nettype wire

>>> design/suffix_automaton_common_substring.sv
// ----------------------------------------------------------------------------
// suffix_automaton_common_substring
// Suffix automaton of a reference string with longest-common-substring query.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; exactly one result
// follows on o_valid for one cycle, and it cannot be stalled. An append to
// a full reference is dropped; else it walks the suffix links from the tail
// and, when a node is met without a solid length, clones it: bitmap and
// link, then each transition target read and written in turn, then links
// checked for redirection. A query byte follows suffix links until a
// transition matches or the root is reached. After reset the block sets up
// the root node before busy drops.
`default_nettype none

module suffix_automaton_common_substring (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_mode,
    input  wire logic [sacs_pkg::SYM_W-1:0]  i_symbol,
    output logic                             o_valid,
    output logic [sacs_pkg::LEN_W-1:0]       o_longest_match,
    output logic [sacs_pkg::LEN_W-1:0]       o_current_match,
    output logic                             o_reference_full
);

    sacs_pkg::t_cmd    cmd;
    sacs_pkg::t_status status;

    sacs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_mode   (i_mode),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    sacs_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_mode           (i_mode),
        .i_symbol         (i_symbol),
        .o_status         (status),
        .o_valid          (o_valid),
        .o_longest_match  (o_longest_match),
        .o_current_match  (o_current_match),
        .o_reference_full (o_reference_full)
    );

endmodule

`default_nettype wire
